[hw/rtl/assert_macros.svh]
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is asserted.
`define TFQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define TFQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/tfq_pkg.sv]
`timescale 1ns / 1ps
package tfq_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned TEMP_W     = 20;
    localparam int unsigned RAW_W      = 14;
    localparam int unsigned JUNC_W     = 12;
    localparam int unsigned FAULT_W    = 4;
    localparam int unsigned COUNT_W    = 8;

    // Window in which a large jump counts as spurious
    localparam logic [31:0] STALE_MS = 32'd1000;

    localparam logic [31:0] FRAME_ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [31:0] FRAME_ALL_ZERO = 32'h0000_0000;
    localparam logic signed [10:0] MEAS_CLIP_HI = 11'sd635;
    localparam logic signed [10:0] MEAS_CLIP_LO = -11'sd635;
    localparam logic signed [TEMP_W-1:0] HUNDREDTHS_PER_QUARTER = 20'sd25;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COOL_OFFSET    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEAT_OFFSET    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_MODE       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE_ENABLE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FAILURE_LIMIT  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_JUMP_LIMIT     = 3'd7;

    // Fault codes
    localparam logic [FAULT_W-1:0] FAULT_OK       = 4'd0;
    localparam logic [FAULT_W-1:0] FAULT_BUS_LOW  = 4'd8;
    localparam logic [FAULT_W-1:0] FAULT_BUS_HIGH = 4'd9;

    // Run mode codes (two-bit signed)
    localparam logic [1:0] MODE_HEATING = 2'b01;

    typedef enum logic [1:0] {
        KIND_FRESH = 2'd0,
        KIND_HELD  = 2'd1,
        KIND_NAN   = 2'd2
    } kind_t;

    typedef struct packed {
        logic signed [15:0] base_offset;
        logic signed [15:0] cool_offset;
        logic signed [15:0] heat_offset;
        logic signed [10:0] measure_offset;
        logic        [1:0]  run_mode;
        logic               measure_enable;
        logic [COUNT_W-1:0] failure_limit;
        logic [RAW_W-1:0]   jump_limit;
    } cfg_t;

    typedef struct packed {
        kind_t                     kind;
        logic signed [TEMP_W-1:0]  temperature;
        logic signed [JUNC_W-1:0]  junction;
        logic [FAULT_W-1:0]        fault;
        logic [FAULT_W-1:0]        prev_fault;
        logic [COUNT_W-1:0]        failures;
    } result_t;

endpackage

[hw/rtl/tfq_cfg_regs.sv]
`timescale 1ns / 1ps
module tfq_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tfq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tfq_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output tfq_pkg::cfg_t                  cfg
);
    import tfq_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_offset    <= '0;
            cfg_reg.cool_offset    <= '0;
            cfg_reg.heat_offset    <= '0;
            cfg_reg.measure_offset <= '0;
            cfg_reg.run_mode       <= '0;
            cfg_reg.measure_enable <= 1'b0;
            cfg_reg.failure_limit  <= 8'd3;
            cfg_reg.jump_limit     <= 14'd40;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BASE_OFFSET:    cfg_reg.base_offset    <= cfg_wdata;
                REG_COOL_OFFSET:    cfg_reg.cool_offset    <= cfg_wdata;
                REG_HEAT_OFFSET:    cfg_reg.heat_offset    <= cfg_wdata;
                REG_MEASURE_OFFSET: cfg_reg.measure_offset <= cfg_wdata[10:0];
                REG_RUN_MODE:       cfg_reg.run_mode       <= cfg_wdata[1:0];
                REG_MEASURE_ENABLE: cfg_reg.measure_enable <= cfg_wdata[0];
                REG_FAILURE_LIMIT:  cfg_reg.failure_limit  <= cfg_wdata[COUNT_W-1:0];
                REG_JUMP_LIMIT:     cfg_reg.jump_limit     <= cfg_wdata[RAW_W-1:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/tfq_update.sv]
`timescale 1ns / 1ps
module tfq_update (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  logic [31:0]     frame,
    input  logic [31:0]     now_ms,
    input  tfq_pkg::cfg_t   cfg,
    output tfq_pkg::result_t res
);
    import tfq_pkg::*;

    logic [FAULT_W-1:0]        fault_status_reg, fault_status_next;
    logic [FAULT_W-1:0]        cached_fault_reg, cached_fault_next;
    logic [COUNT_W-1:0]        failure_count_reg, failure_count_next;
    logic signed [RAW_W-1:0]   raw_temp_reg, raw_temp_next;
    logic signed [RAW_W-1:0]   last_good_reg, last_good_next;
    logic signed [JUNC_W-1:0]  junction_reg, junction_next;
    logic [31:0]               last_read_reg, last_read_next;

    logic [COUNT_W-1:0]        count_pre;
    logic signed [RAW_W:0]     diff;
    logic [RAW_W:0]            diff_mag;
    logic [31:0]               elapsed;
    logic                      spurious;
    logic signed [10:0]        meas_clipped;
    logic signed [TEMP_W-1:0]  offset_sum;
    logic signed [TEMP_W-1:0]  fresh_temp;
    logic signed [TEMP_W-1:0]  held_temp;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        sat_inc = (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    // Frame decode and fault bookkeeping
    always_comb
    begin
        cached_fault_next = cached_fault_reg;
        count_pre         = failure_count_reg;
        if (fault_status_reg != FAULT_OK)
        begin
            cached_fault_next = fault_status_reg;
            count_pre         = sat_inc(failure_count_reg);
        end

        junction_next = junction_reg;
        raw_temp_next = raw_temp_reg;
        if (frame == FRAME_ALL_ZERO)
        begin
            fault_status_next = FAULT_BUS_LOW;
        end
        else if (frame == FRAME_ALL_ONES)
        begin
            fault_status_next = FAULT_BUS_HIGH;
        end
        else
        begin
            fault_status_next = {1'b0, frame[2:0]};
            junction_next     = frame[15:4];
            if (frame[2:0] == 3'd0)
            begin
                raw_temp_next = frame[31:18];
            end
        end
    end

    // Jump filter on the decoded value
    always_comb
    begin
        diff     = (RAW_W+1)'(raw_temp_next) - (RAW_W+1)'(last_good_reg);
        diff_mag = diff[RAW_W] ? (RAW_W+1)'(-diff) : (RAW_W+1)'(diff);
        elapsed  = now_ms - last_read_reg;
        spurious = (diff_mag > (RAW_W+1)'(cfg.jump_limit)) &&
                   (last_good_reg != '0) && (elapsed < STALE_MS);
    end

    // Offsets for a fresh reading
    always_comb
    begin
        meas_clipped = cfg.measure_offset;
        if (cfg.measure_offset < MEAS_CLIP_LO)
        begin
            meas_clipped = MEAS_CLIP_LO;
        end
        else if (cfg.measure_offset > MEAS_CLIP_HI)
        begin
            meas_clipped = MEAS_CLIP_HI;
        end
        offset_sum = TEMP_W'(cfg.base_offset);
        if (cfg.run_mode[1])
        begin
            offset_sum = offset_sum + TEMP_W'(cfg.cool_offset);
        end
        if (cfg.run_mode == MODE_HEATING)
        begin
            offset_sum = offset_sum + TEMP_W'(cfg.heat_offset);
        end
        if (cfg.measure_enable)
        begin
            offset_sum = offset_sum + TEMP_W'(meas_clipped);
        end
        fresh_temp = TEMP_W'(raw_temp_next) * HUNDREDTHS_PER_QUARTER + offset_sum;
        held_temp  = TEMP_W'(last_good_reg) * HUNDREDTHS_PER_QUARTER;
    end

    // Report selection
    always_comb
    begin
        failure_count_next = count_pre;
        if (fault_status_next == FAULT_OK && !spurious)
        begin
            failure_count_next = '0;
        end
        last_good_next = last_good_reg;
        last_read_next = last_read_reg;

        res.junction   = junction_next;
        res.fault      = fault_status_next;
        res.prev_fault = cached_fault_next;

        if (fault_status_next != FAULT_OK && failure_count_next >= cfg.failure_limit)
        begin
            res.kind        = KIND_NAN;
            res.temperature = '0;
        end
        else if (spurious)
        begin
            failure_count_next = sat_inc(failure_count_next);
            res.kind           = KIND_HELD;
            res.temperature    = held_temp;
        end
        else
        begin
            last_good_next  = raw_temp_next;
            last_read_next  = now_ms;
            res.kind        = KIND_FRESH;
            res.temperature = fresh_temp;
        end
        res.failures = failure_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_status_reg  <= FAULT_OK;
            cached_fault_reg  <= FAULT_OK;
            failure_count_reg <= '0;
            raw_temp_reg      <= '0;
            last_good_reg     <= '0;
            junction_reg      <= '0;
            last_read_reg     <= '0;
        end
        else if (fire)
        begin
            fault_status_reg  <= fault_status_next;
            cached_fault_reg  <= cached_fault_next;
            failure_count_reg <= failure_count_next;
            raw_temp_reg      <= raw_temp_next;
            last_good_reg     <= last_good_next;
            junction_reg      <= junction_next;
            last_read_reg     <= last_read_next;
        end
    end

endmodule

[hw/rtl/thermocouple_frame_qualifier_core.sv]
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// input     in_valid / in_stall    frame, now_ms
// output    out_valid / out_stall  result_kind, temperature, junction_temp,
//                                  fault_code, previous_fault, failures
// config    cfg_we                 cfg_index, cfg_wdata
//
// One request per cycle sustained while out_stall stays low; a request goes
// into the input register, then its result into the result register, which
// drives the outputs. The qualifier state updates from the input register
// at the edge that loads the result, so the next request sees it at once.
// Reset (rst_n low, asynchronous) clears state and loads register defaults.
// A stalled result holds in the result register; the input register takes
// one more request behind it, then in_stall rises.
module thermocouple_frame_qualifier_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [31:0]                         frame,
    input  logic [31:0]                         now_ms,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          result_kind,
    output logic signed [tfq_pkg::TEMP_W-1:0]   temperature,
    output logic signed [tfq_pkg::JUNC_W-1:0]   junction_temp,
    output logic [tfq_pkg::FAULT_W-1:0]         fault_code,
    output logic [tfq_pkg::FAULT_W-1:0]         previous_fault,
    output logic [tfq_pkg::COUNT_W-1:0]         failures,
    input  logic                                cfg_we,
    input  logic [tfq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tfq_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import tfq_pkg::*;
    `include "assert_macros.svh"

    cfg_t        cfg;
    result_t     res_comb;
    result_t     result_reg;
    logic        in_vld_reg, in_vld_next;
    logic        out_vld_reg, out_vld_next;
    logic [31:0] frame_reg;
    logic [31:0] now_reg;
    logic        take_in;
    logic        advance;

    tfq_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tfq_update u_update (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .frame  (frame_reg),
        .now_ms (now_reg),
        .cfg    (cfg),
        .res    (res_comb)
    );

    // Advance the held request whenever the result register is free or drains
    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign take_in  = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (take_in)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (advance)
        begin
            out_vld_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Capture the request payload
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            frame_reg <= frame;
            now_reg   <= now_ms;
        end
    end

    // Load the result when the request advances
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= res_comb;
        end
    end

    assign out_valid      = out_vld_reg;
    assign result_kind    = result_reg.kind;
    assign temperature    = result_reg.temperature;
    assign junction_temp  = result_reg.junction;
    assign fault_code     = result_reg.fault;
    assign previous_fault = result_reg.prev_fault;
    assign failures       = result_reg.failures;

    `TFQ_ASSERT(a_nan_has_fault, clk, rst_n, (out_vld_reg && result_reg.kind == KIND_NAN) |-> (result_reg.fault != FAULT_OK), "not-a-number result without a fault")
    `TFQ_ASSERT(a_held_counts, clk, rst_n, (out_vld_reg && result_reg.kind == KIND_HELD) |-> (result_reg.failures != '0), "held result without a failure count")
    `TFQ_ASSERT(a_fresh_ok_clears, clk, rst_n, (out_vld_reg && result_reg.kind == KIND_FRESH && result_reg.fault == FAULT_OK) |-> (result_reg.failures == '0), "clean fresh result left failures")
    `TFQ_ASSERT(a_stall_when_full, clk, rst_n, in_stall |-> (in_vld_reg && out_vld_reg && out_stall), "input stalled with room to advance")
    `TFQ_ASSERT(a_result_from_request, clk, rst_n, $rose(out_vld_reg) |-> $past(in_vld_reg), "result without a held request")

endmodule

[bench/thermocouple_frame_qualifier_core_tb.sv]
`timescale 1ns / 1ps
module thermocouple_frame_qualifier_core_tb;
    import tfq_pkg::*;

    // Run mode encodings beside heating; the block decodes the field as signed
    localparam logic [1:0] MODE_COOL      = 2'b11;
    localparam logic [1:0] MODE_COOL_WIDE = 2'b10;

    // Tracks the qualifier state and the register file, works out the reading
    // each accepted request must produce, and checks readings in order.
    class tc_reading_scoreboard;
        cfg_t                     regs;
        logic [FAULT_W-1:0]       fault_state;
        logic [FAULT_W-1:0]       last_fault;
        logic [COUNT_W-1:0]       fail_count;
        logic signed [RAW_W-1:0]  raw_reading;
        logic signed [RAW_W-1:0]  good_reading;
        logic signed [JUNC_W-1:0] junction;
        logic [31:0]              good_stamp;
        result_t                  expected_readings[$];
        int                       mismatch_count;

        function new();
            regs               = '0;
            regs.failure_limit = 8'd3;
            regs.jump_limit    = 14'd40;
            fault_state        = FAULT_OK;
            last_fault         = FAULT_OK;
            fail_count         = '0;
            raw_reading        = '0;
            good_reading       = '0;
            junction           = '0;
            good_stamp         = '0;
            mismatch_count     = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_BASE_OFFSET:    regs.base_offset    = data;
                REG_COOL_OFFSET:    regs.cool_offset    = data;
                REG_HEAT_OFFSET:    regs.heat_offset    = data;
                REG_MEASURE_OFFSET: regs.measure_offset = data[10:0];
                REG_RUN_MODE:       regs.run_mode       = data[1:0];
                REG_MEASURE_ENABLE: regs.measure_enable = data[0];
                REG_FAILURE_LIMIT:  regs.failure_limit  = data[7:0];
                REG_JUMP_LIMIT:     regs.jump_limit     = data[13:0];
                default:            ;
            endcase
        endfunction

        function void bump_failures();
            if (fail_count != COUNT_MAX)
                fail_count++;
        endfunction

        // A leap beyond the jump limit inside the stale window, from a nonzero
        // last good value, is rejected.
        function bit jump_rejected(logic [31:0] stamp);
            int delta;
            delta = int'($signed(raw_reading)) - int'($signed(good_reading));
            if (delta < 0)
                delta = -delta;
            return delta > int'(regs.jump_limit) && good_reading != 0 &&
                   (stamp - good_stamp) < STALE_MS;
        endfunction

        function void take_request(logic [31:0] word, logic [31:0] stamp);
            result_t r;
            int      offs;
            int      meas;
            if (fault_state != FAULT_OK)
            begin
                last_fault = fault_state;
                bump_failures();
            end
            if (word == FRAME_ALL_ZERO)
                fault_state = FAULT_BUS_LOW;
            else if (word == FRAME_ALL_ONES)
                fault_state = FAULT_BUS_HIGH;
            else
            begin
                fault_state = {1'b0, word[2:0]};
                junction    = word[15:4];
                if (fault_state == FAULT_OK)
                begin
                    raw_reading = word[31:18];
                    if (!jump_rejected(stamp))
                        fail_count = '0;
                end
            end
            r.temperature = '0;
            if (fault_state != FAULT_OK && fail_count >= regs.failure_limit)
                r.kind = KIND_NAN;
            else if (jump_rejected(stamp))
            begin
                bump_failures();
                r.kind        = KIND_HELD;
                r.temperature = TEMP_W'(int'($signed(good_reading)) *
                                        int'(HUNDREDTHS_PER_QUARTER));
            end
            else
            begin
                good_reading = raw_reading;
                offs = int'($signed(regs.base_offset));
                if ($signed(regs.run_mode) < 0)
                    offs += int'($signed(regs.cool_offset));
                if ($signed(regs.run_mode) > 0)
                    offs += int'($signed(regs.heat_offset));
                if (regs.measure_enable)
                begin
                    meas = int'($signed(regs.measure_offset));
                    if (meas < int'(MEAS_CLIP_LO))
                        meas = int'(MEAS_CLIP_LO);
                    if (meas > int'(MEAS_CLIP_HI))
                        meas = int'(MEAS_CLIP_HI);
                    offs += meas;
                end
                good_stamp    = stamp;
                r.kind        = KIND_FRESH;
                r.temperature = TEMP_W'(int'($signed(raw_reading)) *
                                        int'(HUNDREDTHS_PER_QUARTER) + offs);
            end
            r.junction   = junction;
            r.fault      = fault_state;
            r.prev_fault = last_fault;
            r.failures   = fail_count;
            expected_readings.push_back(r);
        endfunction

        function void compare_field(string name, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (got !== want)
            begin
                mismatch_count++;
                $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_reading(logic [1:0] kind, logic signed [TEMP_W-1:0] temp,
                                    logic signed [JUNC_W-1:0] junc, logic [FAULT_W-1:0] fault,
                                    logic [FAULT_W-1:0] prev, logic [COUNT_W-1:0] fails);
            result_t r;
            if (expected_readings.size() == 0)
            begin
                mismatch_count++;
                $display("%0t reading with none pending: expected none actual kind %0d temp %0d",
                         $time, kind, temp);
                return;
            end
            r = expected_readings.pop_front();
            compare_field("result_kind", r.kind, kind);
            compare_field("temperature", r.temperature, temp);
            compare_field("junction_temp", r.junction, junc);
            compare_field("fault_code", r.fault, fault);
            compare_field("previous_fault", r.prev_fault, prev);
            compare_field("failures", r.failures, fails);
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [31:0]              frame;
    logic [31:0]              now_ms;
    logic                     out_valid;
    logic                     out_stall;
    logic [1:0]               result_kind;
    logic signed [TEMP_W-1:0] temperature;
    logic signed [JUNC_W-1:0] junction_temp;
    logic [FAULT_W-1:0]       fault_code;
    logic [FAULT_W-1:0]       previous_fault;
    logic [COUNT_W-1:0]       failures;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_wdata;

    tc_reading_scoreboard sb;

    // Idle percentages for each side and the length of a forced receiver hold-off
    int send_idle_pct;
    int recv_idle_pct;
    int hold_off_cycles;

    // Random walk of the thermocouple field and the running millisecond stamp
    logic signed [RAW_W-1:0] walk_reading;
    logic [31:0]             clock_ms;

    thermocouple_frame_qualifier_core uut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: stall at random, or hold off for a counted stretch on request
    // so that the result register and the input register both fill up.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                out_stall <= 1'b1;
                hold_off_cycles--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Check every reading taken at a rising edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_reading(result_kind, temperature, junction_temp, fault_code,
                             previous_fault, failures);
    end

    // Guard against a hang: far beyond the slowest correct run
    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic [31:0] tc_frame(logic [13:0] tc, logic [11:0] junc,
                                             logic [2:0] fault);
        return {tc, 2'b00, junc, 1'b0, fault};
    endfunction

    // Build a random frame. Most are well formed fault-free readings that walk
    // slowly around the last value, so the jump filter sees small and large
    // steps; the rest are fault bits and a stuck bus. A storm sends faults only.
    function automatic logic [31:0] next_frame(bit storm);
        int          pick;
        int          step;
        logic [31:0] word;
        pick = storm ? $urandom_range(0, 19) : $urandom_range(0, 99);
        word = $urandom;
        if (pick < 3)
            return FRAME_ALL_ZERO;
        if (pick < 6)
            return FRAME_ALL_ONES;
        if (pick < 20)
        begin
            word[2:0] = 3'($urandom_range(1, 7));
            return word;
        end
        if (pick < 24)
            walk_reading = '0;
        else if (pick < 32)
            walk_reading = RAW_W'($urandom);
        else
        begin
            step = int'($urandom_range(0, 100)) - 50;
            walk_reading = RAW_W'(int'(walk_reading) + step);
        end
        word[31:18] = walk_reading;
        word[2:0]   = 3'b000;
        return word;
    endfunction

    // Advance time mostly inside the stale window, sometimes past it, and now
    // and then jump anywhere so the stamp wraps.
    function automatic logic [31:0] next_stamp();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            clock_ms = clock_ms + $urandom_range(1000, 5000);
        else if (pick < 13)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms + $urandom_range(0, 400);
        return clock_ms;
    endfunction

    // Offer one request, idling first at random; hold it until it is taken
    task automatic send_request(input logic [31:0] word, input logic [31:0] stamp);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        frame    <= word;
        now_ms   <= stamp;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        sb.take_request(word, stamp);
    endtask

    // Drop valid and wait for every pending reading, plus a margin beyond the pipeline depth
    task automatic drain_readings();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_readings.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        sb.set_register(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Load a full register setting; only called with the block idle
    task automatic apply_setting(input int which);
        case (which)
            1:
            begin
                // Positive extremes, measure offset above the clip, heating,
                // zero limit and zero jump tolerance
                write_reg(REG_BASE_OFFSET, 16'h7FFF);
                write_reg(REG_COOL_OFFSET, 16'h8001);
                write_reg(REG_HEAT_OFFSET, 16'h7FFF);
                write_reg(REG_MEASURE_OFFSET, 16'h03FF);
                write_reg(REG_RUN_MODE, CFG_DATA_W'(MODE_HEATING));
                write_reg(REG_MEASURE_ENABLE, 16'h0001);
                write_reg(REG_FAILURE_LIMIT, 16'h0000);
                write_reg(REG_JUMP_LIMIT, 16'h0000);
            end
            2:
            begin
                // Negative extremes, measure offset below the clip, the wide
                // cooling pattern, largest limit and jump tolerance
                write_reg(REG_BASE_OFFSET, 16'h8001);
                write_reg(REG_COOL_OFFSET, 16'h8001);
                write_reg(REG_HEAT_OFFSET, 16'd100);
                write_reg(REG_MEASURE_OFFSET, 16'h0400);
                write_reg(REG_RUN_MODE, CFG_DATA_W'(MODE_COOL_WIDE));
                write_reg(REG_MEASURE_ENABLE, 16'h0001);
                write_reg(REG_FAILURE_LIMIT, 16'h00FF);
                write_reg(REG_JUMP_LIMIT, 16'h3FFF);
            end
            3:
            begin
                write_reg(REG_BASE_OFFSET, 16'd250);
                write_reg(REG_COOL_OFFSET, 16'hFF6A);
                write_reg(REG_HEAT_OFFSET, 16'd300);
                write_reg(REG_MEASURE_OFFSET, 16'hFF38);
                write_reg(REG_RUN_MODE, CFG_DATA_W'(MODE_COOL));
                write_reg(REG_MEASURE_ENABLE, 16'h0000);
                write_reg(REG_FAILURE_LIMIT, 16'd5);
                write_reg(REG_JUMP_LIMIT, 16'd20);
            end
            default:
            begin
                // Random data on every bit, with a small limit and tolerance
                // so that faults and held readings stay common
                write_reg(REG_BASE_OFFSET, 16'($urandom));
                write_reg(REG_COOL_OFFSET, 16'($urandom));
                write_reg(REG_HEAT_OFFSET, 16'($urandom));
                write_reg(REG_MEASURE_OFFSET, 16'($urandom));
                write_reg(REG_RUN_MODE, 16'($urandom));
                write_reg(REG_MEASURE_ENABLE, 16'($urandom));
                write_reg(REG_FAILURE_LIMIT, 16'($urandom_range(0, 6)));
                write_reg(REG_JUMP_LIMIT, 16'($urandom_range(0, 200)));
            end
        endcase
    endtask

    // Random requests; the first storm_len are faults only, then drain
    task automatic run_phase(input int count, input int storm_len);
        logic [31:0] word;
        logic [31:0] stamp;
        for (int i = 0; i < count; i++)
        begin
            word  = next_frame(i < storm_len);
            stamp = next_stamp();
            send_request(word, stamp);
        end
        drain_readings();
    endtask

    initial
    begin
        sb              = new();
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        hold_off_cycles = 0;
        walk_reading    = '0;
        clock_ms        = '0;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        frame           = '0;
        now_ms          = '0;
        cfg_we          = 1'b0;
        cfg_index       = REG_BASE_OFFSET;
        cfg_wdata       = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed requests on the reset setting: stuck bus both ways, every
        // fault bit pattern until the failure count reports not-a-number,
        // both thermocouple extremes, the jump filter on either side of the
        // tolerance and of the stale window, a zero last good value, a
        // faulted frame passing the old reading, and a wrapped stamp.
        send_idle_pct = 27;
        recv_idle_pct = 80;
        send_request(FRAME_ALL_ZERO, 32'd0);
        send_request(FRAME_ALL_ONES, 32'd10);
        for (int k = 1; k <= 7; k++)
            send_request(tc_frame(14'h0AAA, k[0] ? 12'h7FF : 12'h800, 3'(k)), 32'(20 + k));
        send_request(tc_frame(14'h1FFF, 12'h000, 3'd0), 32'd100);
        send_request(tc_frame(14'h2000, 12'hFFF, 3'd0), 32'd200);
        send_request(tc_frame(14'h2000, 12'h001, 3'd0), 32'd1100);
        send_request(tc_frame(14'h2028, 12'h002, 3'd0), 32'd1200);
        send_request(tc_frame(14'h2051, 12'h003, 3'd0), 32'd2199);
        send_request(tc_frame(14'h2051, 12'h004, 3'd0), 32'd2200);
        send_request(tc_frame(14'h0000, 12'h5A5, 3'd4), 32'd2300);
        send_request(tc_frame(14'h0000, 12'h123, 3'd0), 32'd9000);
        send_request(tc_frame(14'h1FFF, 12'h7FF, 3'd0), 32'd9001);
        send_request(tc_frame(14'h0100, 12'h800, 3'd0), 32'hFFFF_FFF0);
        send_request(tc_frame(14'h1F00, 12'h000, 3'd0), 32'h0000_0100);
        send_request(tc_frame(14'h1555, 12'hAAA, 3'd0) | 32'h0003_0008, 32'h8000_0000);
        drain_readings();

        // Slow receiver
        run_phase(180, 0);
        apply_setting(1);
        run_phase(180, 0);

        // Slow sender; a long fault storm drives the counter to saturation
        send_idle_pct = 80;
        recv_idle_pct = 27;
        apply_setting(2);
        run_phase(450, 270);
        apply_setting(3);
        run_phase(180, 0);

        // Full rate; hold off the receiver first so the input stalls
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_setting(0);
        hold_off_cycles = 64;
        run_phase(180, 0);
        apply_setting(0);
        run_phase(180, 0);

        if (sb.mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
